@@ design/dtnp_pkg.sv @@
`default_nettype none

package dtnp_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned MANT_W      = 60;
  localparam int unsigned FRAC_W      = 5;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_TDATA_W = 72;

  // Most digits kept in the mantissa (1 to 19)
  localparam int unsigned MAX_DIGITS = 18;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FORMAT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LONG   = 2'd3;

  typedef struct packed {
    logic              fire;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } step_t;

  typedef struct packed {
    logic                valid;
    logic [MANT_W-1:0]   mantissa;
    logic [FRAC_W-1:0]   frac_digits;
    logic                negative;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

@@ design/dtnp_in_stage.sv @@
`default_nettype none

module dtnp_in_stage (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [dtnp_pkg::CHAR_W-1:0]  in_tdata,
  input  wire                          in_tlast,
  input  wire                          out_free,
  output dtnp_pkg::step_t              step
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [dtnp_pkg::CHAR_W-1:0]  char_r;
  logic                         last_r;
  logic                         adv;
  logic                         take;

  // A byte without a result never waits; a final byte waits for room downstream
  assign adv       = valid_r && (!last_r || out_free);
  assign in_tready = !valid_r || adv;
  assign take      = in_tvalid && in_tready;
  assign valid_nxt = take || (valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign step.fire      = adv;
  assign step.char_code = char_r;
  assign step.last_char = last_r;

endmodule

`default_nettype wire

@@ design/dtnp_parse_step.sv @@
`default_nettype none

module dtnp_parse_step (
  input  wire              clk,
  input  wire              rst_n,
  input  dtnp_pkg::step_t  step,
  output dtnp_pkg::result_t res
);

  logic                                started_r, started_nxt;
  logic                                sign_neg_r, sign_neg_nxt;
  logic                                point_seen_r, point_seen_nxt;
  logic [dtnp_pkg::MANT_W-1:0]         digit_accum_r, digit_accum_nxt;
  logic [dtnp_pkg::CNT_W-1:0]          digit_count_r, digit_count_nxt;
  logic [dtnp_pkg::FRAC_W-1:0]         frac_count_r, frac_count_nxt;
  logic                                format_bad_r, format_bad_nxt;
  logic                                too_long_r, too_long_nxt;

  logic                                k_started, k_sign_neg, k_point_seen;
  logic [dtnp_pkg::MANT_W-1:0]         k_accum;
  logic [dtnp_pkg::CNT_W-1:0]          k_count;
  logic [dtnp_pkg::FRAC_W-1:0]         k_frac;
  logic                                k_format_bad, k_too_long;

  logic [dtnp_pkg::CHAR_W-1:0]         c;
  logic                                is_digit, is_sign, is_point, kept, restart;
  logic [63:0]                         acc_ext, acc_next;
  logic                                no_room;
  logic [dtnp_pkg::STATUS_W-1:0]       status;

  assign c        = step.char_code;
  assign is_digit = (c >= dtnp_pkg::CH_ZERO) && (c <= dtnp_pkg::CH_NINE);
  assign is_sign  = (c == dtnp_pkg::CH_PLUS) || (c == dtnp_pkg::CH_MINUS);
  assign is_point = (c == dtnp_pkg::CH_POINT);
  assign kept     = is_digit || is_sign || is_point;
  assign restart  = !step.last_char &&
                    ((c == dtnp_pkg::CH_EQUAL) || (c == dtnp_pkg::CH_COLON));

  // accum * 10 + digit, with four guard bits to catch a carry past the mantissa
  assign acc_ext  = {4'b0000, digit_accum_r};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {60'd0, c[3:0]};
  assign no_room  = (digit_count_r >= dtnp_pkg::CNT_W'(dtnp_pkg::MAX_DIGITS)) ||
                    (acc_next[63:dtnp_pkg::MANT_W] != 4'b0000);

  always_comb begin
    k_started    = started_r;
    k_sign_neg   = sign_neg_r;
    k_point_seen = point_seen_r;
    k_accum      = digit_accum_r;
    k_count      = digit_count_r;
    k_frac       = frac_count_r;
    k_format_bad = format_bad_r;
    k_too_long   = too_long_r;
    if (kept) begin
      k_started = 1'b1;
      if (!format_bad_r) begin
        if (is_sign) begin
          if (started_r) begin
            k_format_bad = 1'b1;
          end else if (c == dtnp_pkg::CH_MINUS) begin
            k_sign_neg = 1'b1;
          end
        end else if (is_point) begin
          if (point_seen_r) begin
            k_format_bad = 1'b1;
          end else begin
            k_point_seen = 1'b1;
          end
        end else if (no_room) begin
          k_too_long = 1'b1;
        end else begin
          k_accum = acc_next[dtnp_pkg::MANT_W-1:0];
          k_count = digit_count_r + 1'b1;
          if (point_seen_r) begin
            k_frac = frac_count_r + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (!k_started) begin
      status = dtnp_pkg::ST_EMPTY;
    end else if (k_format_bad) begin
      status = dtnp_pkg::ST_FORMAT;
    end else if (k_too_long) begin
      status = dtnp_pkg::ST_LONG;
    end else begin
      status = dtnp_pkg::ST_OK;
    end
  end

  always_comb begin
    res.valid = step.fire && step.last_char;
    res.status = status;
    if (status == dtnp_pkg::ST_OK) begin
      res.mantissa    = k_accum;
      res.frac_digits = k_frac;
      res.negative    = k_sign_neg;
    end else begin
      res.mantissa    = '0;
      res.frac_digits = '0;
      res.negative    = 1'b0;
    end
  end

  always_comb begin
    started_nxt     = started_r;
    sign_neg_nxt    = sign_neg_r;
    point_seen_nxt  = point_seen_r;
    digit_accum_nxt = digit_accum_r;
    digit_count_nxt = digit_count_r;
    frac_count_nxt  = frac_count_r;
    format_bad_nxt  = format_bad_r;
    too_long_nxt    = too_long_r;
    if (step.fire) begin
      if (step.last_char || restart) begin
        // clear for the next text
        started_nxt     = 1'b0;
        sign_neg_nxt    = 1'b0;
        point_seen_nxt  = 1'b0;
        digit_accum_nxt = '0;
        digit_count_nxt = '0;
        frac_count_nxt  = '0;
        format_bad_nxt  = 1'b0;
        too_long_nxt    = 1'b0;
      end else begin
        started_nxt     = k_started;
        sign_neg_nxt    = k_sign_neg;
        point_seen_nxt  = k_point_seen;
        digit_accum_nxt = k_accum;
        digit_count_nxt = k_count;
        frac_count_nxt  = k_frac;
        format_bad_nxt  = k_format_bad;
        too_long_nxt    = k_too_long;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r     <= 1'b0;
      sign_neg_r    <= 1'b0;
      point_seen_r  <= 1'b0;
      digit_accum_r <= '0;
      digit_count_r <= '0;
      frac_count_r  <= '0;
      format_bad_r  <= 1'b0;
      too_long_r    <= 1'b0;
    end else begin
      started_r     <= started_nxt;
      sign_neg_r    <= sign_neg_nxt;
      point_seen_r  <= point_seen_nxt;
      digit_accum_r <= digit_accum_nxt;
      digit_count_r <= digit_count_nxt;
      frac_count_r  <= frac_count_nxt;
      format_bad_r  <= format_bad_nxt;
      too_long_r    <= too_long_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r <= dtnp_pkg::CNT_W'(dtnp_pkg::MAX_DIGITS))
    else $error("digit count past limit");

  a_frac_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    frac_count_r <= digit_count_r)
    else $error("fraction count exceeds digit count");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (digit_count_r == '0) && !format_bad_r && !too_long_r)
    else $error("state set before any kept byte");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && step.last_char |=> !started_r && (digit_accum_r == '0))
    else $error("state not cleared after final byte");
`endif

endmodule

`default_nettype wire

@@ design/dtnp_out_stage.sv @@
`default_nettype none

module dtnp_out_stage (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  dtnp_pkg::result_t                   res,
  output logic                                out_free,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [dtnp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [dtnp_pkg::STATUS_W-1:0]       out_tuser
);

  logic                                valid_r, valid_nxt;
  logic [dtnp_pkg::MANT_W-1:0]         mant_r;
  logic [dtnp_pkg::FRAC_W-1:0]         frac_r;
  logic                                neg_r;
  logic [dtnp_pkg::STATUS_W-1:0]       status_r;

  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res.valid || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      mant_r   <= res.mantissa;
      frac_r   <= res.frac_digits;
      neg_r    <= res.negative;
      status_r <= res.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, neg_r, frac_r, mant_r};
  assign out_tuser  = status_r;

`ifndef NO_ASSERTIONS
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (status_r != dtnp_pkg::ST_OK) |->
      (mant_r == '0) && (frac_r == '0) && !neg_r)
    else $error("error result carries nonzero fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result loaded over a held item");
`endif

endmodule

`default_nettype wire

@@ design/decimal_text_number_parser.sv @@
// Decimal text number parser.
// Input channel (in_*): one ASCII byte per item, in_tlast on the final byte
// of a text. Digits, '.', '+' and '-' are parsed; '=' or ':' before the
// final byte restarts the parse; all other bytes are dropped.
// Result channel (out_*): one item per text, sent for the final byte. The
// value is mantissa / 10^frac_digits, negated when the negative bit is set;
// out_tuser carries the status (ok, empty, format error, too many digits).
// A final byte goes through the input register and then the result register
// on its way to out_tvalid.
// Throughput: one byte per cycle while no final byte waits for a held result;
// the multiply-by-ten and add on the running mantissa is combinational.
// Reset (rst_n low, synchronous) empties both registers and clears the
// parse state. When the receiver stalls, the result is held; non-final
// bytes still flow, and a further final byte waits in the input register,
// dropping in_tready, until the held result is taken.
`default_nettype none

module decimal_text_number_parser (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [dtnp_pkg::CHAR_W-1:0]         in_tdata,   // [7:0] char_code
  input  wire                                 in_tlast,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [59:0] mantissa, [64:60] frac_digits, [65] negative, [71:66] zero
  output logic [dtnp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [dtnp_pkg::STATUS_W-1:0]       out_tuser   // [1:0] status
);

  dtnp_pkg::step_t   step;
  dtnp_pkg::result_t res;
  logic              out_free;

  dtnp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_free  (out_free),
    .step      (step)
  );

  dtnp_parse_step u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  dtnp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
